[hdl/ssi_pkg.sv]
// Shared types, codes and constants for the servo slew interpolator.
package ssi_pkg;

  localparam int CHANNELS_DEF  = 6;
  localparam int FRAC_BITS_DEF = 4;

  localparam int KIND_W = 3;
  localparam int CH_W   = 4;
  localparam int DEG_W  = 8;
  localparam int SPD_W  = 12;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_IMM    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SMOOTH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CENTER = 3'd4;

  localparam logic [0:0] REG_DEFAULT_SPEED = 1'b0;

  localparam logic [DEG_W-1:0] CENTER_DEG = 8'd90;
  localparam logic [DEG_W-1:0] MAX_DEG    = 8'd180;
  localparam logic [SPD_W-1:0] DEF_SPEED_RST = 12'd16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   channel;
    logic [DEG_W-1:0]  angle;
    logic [SPD_W-1:0]  speed;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [DEG_W-1:0] out_angle;
    logic             is_query_answer;
    logic             last;
  } out_item_t;

endpackage

[hdl/ssi_step_unit.sv]
// Shared slew step unit: distance, snap test, clamped step and whole-degree angle.
module ssi_step_unit
  import ssi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int ANG_W = DEG_W + FRAC_BITS
) (
  input  logic             step_en,
  input  logic [ANG_W-1:0] cur,
  input  logic [ANG_W-1:0] tgt,
  input  logic [SPD_W-1:0] step,
  output logic [ANG_W-1:0] new_cur,
  output logic             snap,
  output logic [DEG_W-1:0] deg
);

  localparam int CMP_W = (ANG_W > SPD_W) ? ANG_W : SPD_W;
  localparam logic [ANG_W-1:0] HALF = ANG_W'((1 << FRAC_BITS) >> 1);

  logic             up;
  logic [ANG_W-1:0] gap;
  logic [ANG_W-1:0] st;
  logic [ANG_W-1:0] moved;
  logic [DEG_W-1:0] whole;

  assign up   = tgt > cur;
  assign gap  = up ? (tgt - cur) : (cur - tgt);
  assign snap = gap <= HALF;
  assign st   = (CMP_W'(step) > CMP_W'(gap)) ? gap : ANG_W'(step);
  assign moved = snap ? tgt : (up ? (cur + st) : (cur - st));

  assign new_cur = step_en ? moved : cur;
  assign whole   = DEG_W'(new_cur >> FRAC_BITS);
  assign deg     = (whole > MAX_DEG) ? MAX_DEG : whole;

endmodule

[hdl/servo_slew_interpolator.sv]
// Servo slew interpolator top level: item sequencer, channel state and output register.
//
// Usage: items enter on in_valid/in_ready (in_data) and results leave on
// out_valid/out_ready (out_data). default_speed is written over the APB-style
// port at byte address 0; reads return it. pready is always high.
// An item is taken only when the block is idle. Immediate move, smooth move
// and query are handled in the execute state after acceptance; tick and center
// walk the channels one per cycle through the shared step unit. Each result is
// loaded into a one-deep output register; a result is visible on the cycle
// after it is produced, and the final result of an item carries last. When the
// receiver stalls, the walk holds on the current channel until the output
// register frees. The block takes no new item until it is done with the last
// one, as it has one step unit and a one-deep output register.
// Reset puts every channel at 90 degrees, stopped, with step 16 and
// default_speed 16; no result is pending after reset.
module servo_slew_interpolator
  import ssi_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int ANG_W = DEG_W + FRAC_BITS;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [ANG_W-1:0] CENTER_ANG = ANG_W'(CENTER_DEG) << FRAC_BITS;
  localparam logic [ANG_W-1:0] MAX_ANG = ANG_W'(MAX_DEG) << FRAC_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  in_item_t         item_r;
  logic [SPD_W-1:0] def_speed_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [ANG_W-1:0] cur_r  [CHANNELS];
  logic [ANG_W-1:0] tgt_r  [CHANNELS];
  logic [SPD_W-1:0] step_r [CHANNELS];
  logic [CHANNELS-1:0] motion_r;

  logic             in_fire;
  logic             cfg_wr;
  logic             slot_free;
  logic             ch_ok;
  logic [IDX_W-1:0] ci;
  logic [IDX_W-1:0] rd_idx;
  logic             later_moving;
  logic [ANG_W-1:0] new_cur;
  logic             snap;
  logic [DEG_W-1:0] unit_deg;
  logic [ANG_W-1:0] deg_ang;

  logic             set_pos;
  logic             set_smooth;
  logic             step_wr;
  logic [IDX_W-1:0] wr_idx;
  logic [ANG_W-1:0] pos_val;
  logic             load_out;
  out_item_t        out_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_DEFAULT_SPEED);
  assign prdata    = (paddr[2] == REG_DEFAULT_SPEED) ? PDATA_W'(def_speed_r) : '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  assign ci      = item_r.channel[IDX_W-1:0];
  assign ch_ok   = {1'b0, item_r.channel} < (CH_W + 1)'(CHANNELS);
  assign rd_idx  = (state_r == S_WALK) ? idx_r : ci;
  assign deg_ang = ANG_W'(item_r.angle) << FRAC_BITS;

  always_comb begin
    later_moving = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      if (motion_r[j] && (IDX_W'(j) > idx_r)) begin
        later_moving = 1'b1;
      end
    end
  end

  ssi_step_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .step_en (state_r == S_WALK),
    .cur     (cur_r[rd_idx]),
    .tgt     (tgt_r[rd_idx]),
    .step    (step_r[rd_idx]),
    .new_cur (new_cur),
    .snap    (snap),
    .deg     (unit_deg)
  );

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    set_pos    = 1'b0;
    set_smooth = 1'b0;
    step_wr    = 1'b0;
    wr_idx     = ci;
    pos_val    = deg_ang;
    load_out   = 1'b0;
    out_nxt    = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_r.kind)
          KIND_IMM: begin
            if (!ch_ok) begin
              state_nxt = S_IDLE;
            end else if (slot_free) begin
              set_pos   = 1'b1;
              load_out  = 1'b1;
              out_nxt   = '{out_channel: item_r.channel, out_angle: item_r.angle,
                            is_query_answer: 1'b0, last: 1'b1};
              state_nxt = S_IDLE;
            end
          end
          KIND_SMOOTH: begin
            set_smooth = ch_ok;
            state_nxt  = S_IDLE;
          end
          KIND_QUERY: begin
            if (slot_free) begin
              load_out  = 1'b1;
              out_nxt   = '{out_channel: item_r.channel,
                            out_angle: ch_ok ? unit_deg : CENTER_DEG,
                            is_query_answer: 1'b1, last: 1'b1};
              state_nxt = S_IDLE;
            end
          end
          KIND_TICK, KIND_CENTER: begin
            idx_nxt   = '0;
            state_nxt = S_WALK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        wr_idx  = idx_r;
        pos_val = CENTER_ANG;
        if (item_r.kind == KIND_TICK) begin
          if (motion_r[idx_r] && slot_free) begin
            step_wr  = 1'b1;
            load_out = 1'b1;
            out_nxt  = '{out_channel: CH_W'(idx_r), out_angle: unit_deg,
                         is_query_answer: 1'b0, last: !later_moving};
          end
        end else if (slot_free) begin
          set_pos  = 1'b1;
          load_out = 1'b1;
          out_nxt  = '{out_channel: CH_W'(idx_r), out_angle: CENTER_DEG,
                       is_query_answer: 1'b0, last: idx_r == LAST_IDX};
        end
        if (load_out || ((item_r.kind == KIND_TICK) && !motion_r[idx_r])) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      def_speed_r <= DEF_SPEED_RST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        def_speed_r <= pwdata[SPD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.kind    <= in_data.kind;
      item_r.channel <= in_data.channel;
      item_r.angle   <= (in_data.angle > MAX_DEG) ? MAX_DEG : in_data.angle;
      item_r.speed   <= in_data.speed;
    end
    if (load_out) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i]  <= CENTER_ANG;
        tgt_r[i]  <= CENTER_ANG;
        step_r[i] <= DEF_SPEED_RST;
      end
      motion_r <= '0;
    end else begin
      if (set_pos) begin
        cur_r[wr_idx]    <= pos_val;
        tgt_r[wr_idx]    <= pos_val;
        motion_r[wr_idx] <= 1'b0;
      end
      if (set_smooth) begin
        tgt_r[wr_idx]    <= deg_ang;
        step_r[wr_idx]   <= (item_r.speed != '0) ? item_r.speed : def_speed_r;
        motion_r[wr_idx] <= 1'b1;
      end
      if (step_wr) begin
        cur_r[wr_idx] <= new_cur;
        if (snap) begin
          motion_r[wr_idx] <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (cur_r[idx_r] <= MAX_ANG) && (tgt_r[idx_r] <= MAX_ANG))
    else $error("channel angle out of range");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_wr |-> (new_cur <= MAX_ANG))
    else $error("stepped angle out of range");

  a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_query_answer |-> out_data_r.last)
    else $error("query answer without last");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && out_nxt.last |=> !load_out)
    else $error("result produced right after the final beat");
`endif

endmodule
